FILE: design/sbh_pkg.sv
// shared constants and types for the slab boundary hit block
package sbh_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DIR_WIDTH   = 16;
  localparam int TOL_WIDTH   = 16;
  localparam int CFG_IDX_WIDTH = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_BOTTOM = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TOP    = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TOL    = 2'd2;

  // face codes of a result item
  typedef enum logic [1:0] {
    FACE_NONE  = 2'd0,
    FACE_LOWER = 2'd1,
    FACE_UPPER = 2'd2
  } face_t;

endpackage

FILE: design/sbh_ray_if.sv
// ray item channel: point and direction
interface sbh_ray_if #(
  parameter int CW = sbh_pkg::COORD_WIDTH,
  parameter int DW = sbh_pkg::DIR_WIDTH
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] pos_x;
  logic [CW-1:0] pos_y;
  logic [CW-1:0] pos_z;
  logic [DW-1:0] dir_x;
  logic [DW-1:0] dir_y;
  logic [DW-1:0] dir_z;

  modport source (output valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, output ready);
endinterface

FILE: design/sbh_hit_if.sv
// result item channel: face, distance and hit point
interface sbh_hit_if #(
  parameter int CW = sbh_pkg::COORD_WIDTH
);
  logic          valid;
  logic          ready;
  logic [1:0]    face;
  logic          outside;
  logic [CW-1:0] distance;
  logic [CW-1:0] hit_x;
  logic [CW-1:0] hit_y;
  logic [CW-1:0] hit_z;
  logic          saturated;

  modport source (output valid, face, outside, distance, hit_x, hit_y, hit_z, saturated,
                  input ready);
  modport sink (input valid, face, outside, distance, hit_x, hit_y, hit_z, saturated,
                output ready);
endinterface

FILE: design/sbh_cfg_if.sv
// configuration write channel
interface sbh_cfg_if #(
  parameter int CW = sbh_pkg::COORD_WIDTH
);
  logic                             valid;
  logic                             ready;
  logic [sbh_pkg::CFG_IDX_WIDTH-1:0] index;
  logic [CW-1:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/slab_boundary_hit.sv
// slab boundary hit: pipelined ray to slab face distance and hit point
// One item is taken every cycle while the output register is free; each ray passes stages
// a to e, the square root pipeline with one root bit per stage, the divider pipeline
// with one quotient bit per stage and then the output register. The
// whole pipeline moves together and holds when a finished result is not taken; the
// configuration port always accepts and its writes belong in idle periods.
module slab_boundary_hit #(
  parameter int COORD_WIDTH = sbh_pkg::COORD_WIDTH,
  parameter int DIR_WIDTH   = sbh_pkg::DIR_WIDTH
) (
  input logic     clk,
  input logic     rst,
  sbh_ray_if.sink ray,
  sbh_hit_if.source hit,
  sbh_cfg_if.sink cfg
);

  localparam int C   = COORD_WIDTH;
  localparam int D   = DIR_WIDTH;
  localparam int TW  = sbh_pkg::TOL_WIDTH;
  localparam int AW  = C + 1;            // path along z magnitude
  localparam int SW  = 2 * D;            // squared direction length
  localparam int XW  = 2 * AW + SW;      // radicand
  localparam int RW  = XW / 2;           // root width
  localparam int MW  = D + AW;           // lateral product width
  localparam int LW  = RW;               // divider stages (RW equals MW)
  // sideband: flags {outside, zero, stay, up, neg_x, neg_y}, px, py, pz, fz, adz
  localparam int SBW = 6 + 4 * C + D;
  localparam int O_ADZ = 0;
  localparam int O_FZ  = D;
  localparam int O_PZ  = D + C;
  localparam int O_PY  = D + 2 * C;
  localparam int O_PX  = D + 3 * C;
  localparam int O_FL  = D + 4 * C;

  // configuration registers
  logic [C-1:0]  slab_bottom;
  logic [C-1:0]  slab_top;
  logic [TW-1:0] tolerance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slab_bottom <= '0;
      slab_top    <= C'(1) << sbh_pkg::FRAC_BITS;
      tolerance   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        sbh_pkg::CFG_BOTTOM: slab_bottom <= cfg.data;
        sbh_pkg::CFG_TOP:    slab_top    <= cfg.data;
        sbh_pkg::CFG_TOL:    tolerance   <= cfg.data[TW-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances when the output register is free
  logic adv;
  assign adv       = !hit.valid || hit.ready;
  assign ray.ready = adv;

  // stage a: inside test, face choice, magnitudes
  logic [C+1:0] pz_e, lo_lim, hi_lim;
  logic         in_out, in_up, in_stay;
  logic [C-1:0] in_fz;
  logic [C:0]   in_n, in_an;
  logic [D-1:0] in_adx, in_ady, in_adz;

  always_comb begin
    pz_e   = {{2{ray.pos_z[C-1]}}, ray.pos_z};
    lo_lim = {{2{slab_bottom[C-1]}}, slab_bottom} - {{(C+2-TW){1'b0}}, tolerance};
    hi_lim = {{2{slab_top[C-1]}}, slab_top} + {{(C+2-TW){1'b0}}, tolerance};
    in_out = ($signed(pz_e) < $signed(lo_lim)) || ($signed(pz_e) > $signed(hi_lim));
    in_up  = !ray.dir_z[D-1] && (ray.dir_z != '0);
    in_fz  = in_up ? slab_top : slab_bottom;
    in_n   = {in_fz[C-1], in_fz} - {ray.pos_z[C-1], ray.pos_z};
    in_stay = (in_n == '0) || ((!in_n[C]) != in_up);
    in_an  = in_n[C] ? (~in_n + (C+1)'(1)) : in_n;
    in_adx = ray.dir_x[D-1] ? (~ray.dir_x + D'(1)) : ray.dir_x;
    in_ady = ray.dir_y[D-1] ? (~ray.dir_y + D'(1)) : ray.dir_y;
    in_adz = ray.dir_z[D-1] ? (~ray.dir_z + D'(1)) : ray.dir_z;
  end

  logic           a_vld;
  logic [SBW-1:0] a_sb;
  logic [AW-1:0]  a_an;
  logic [D-1:0]   a_adx, a_ady;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= ray.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sb  <= {in_out, (ray.dir_z == '0), in_stay, in_up, ray.dir_x[D-1], ray.dir_y[D-1],
                ray.pos_x, ray.pos_y, ray.pos_z, in_fz, in_adz};
      a_an  <= in_an;
      a_adx <= in_adx;
      a_ady <= in_ady;
    end
  end

  // stage b: squares and lateral products
  logic           b_vld;
  logic [SBW-1:0] b_sb;
  logic [SW-1:0]  b_sqx, b_sqy, b_sqz;
  logic [2*AW-1:0] b_an2;
  logic [MW-1:0]  b_mx, b_my;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sb  <= a_sb;
      b_sqx <= a_adx * a_adx;
      b_sqy <= a_ady * a_ady;
      b_sqz <= a_sb[O_ADZ +: D] * a_sb[O_ADZ +: D];
      b_an2 <= a_an * a_an;
      b_mx  <= a_adx * a_an;
      b_my  <= a_ady * a_an;
    end
  end

  // stage c: squared direction length
  logic            c_vld;
  logic [SBW-1:0]  c_sb;
  logic [SW-1:0]   c_s;
  logic [2*AW-1:0] c_an2;
  logic [MW-1:0]   c_mx, c_my;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_sb  <= b_sb;
      c_s   <= b_sqx + b_sqy + b_sqz;
      c_an2 <= b_an2;
      c_mx  <= b_mx;
      c_my  <= b_my;
    end
  end

  // stage d: radicand partial products
  logic             d_vld;
  logic [SBW-1:0]   d_sb;
  logic [AW+SW-1:0] d_plo, d_phi;
  logic [MW-1:0]    d_mx, d_my;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (adv) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_sb  <= c_sb;
      d_plo <= c_an2[AW-1:0] * c_s;
      d_phi <= c_an2[2*AW-1:AW] * c_s;
      d_mx  <= c_mx;
      d_my  <= c_my;
    end
  end

  // stage e: radicand sum
  logic           e_vld;
  logic [SBW-1:0] e_sb;
  logic [XW-1:0]  e_x;
  logic [MW-1:0]  e_mx, e_my;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_sb <= d_sb;
      e_x  <= XW'(d_plo) + (XW'(d_phi) << AW);
      e_mx <= d_mx;
      e_my <= d_my;
    end
  end

  // square root pipeline, one root bit per stage
  logic           sq_vld  [0:RW];
  logic [SBW-1:0] sq_sb   [0:RW];
  logic [RW:0]    sq_rem  [0:RW];
  logic [RW-1:0]  sq_root [0:RW];
  logic [XW-1:0]  sq_x    [0:RW];
  logic [MW-1:0]  sq_mx   [0:RW];
  logic [MW-1:0]  sq_my   [0:RW];

  assign sq_vld[0]  = e_vld;
  assign sq_sb[0]   = e_sb;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_x[0]    = e_x;
  assign sq_mx[0]   = e_mx;
  assign sq_my[0]   = e_my;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RW+2:0] cur, trial;
    logic          ge;

    always_comb begin
      cur   = {sq_rem[k], sq_x[k][XW-1:XW-2]};
      trial = {1'b0, sq_root[k], 2'b01};
      ge    = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_sb[k+1]   <= sq_sb[k];
        sq_rem[k+1]  <= ge ? (RW+1)'(cur - trial) : cur[RW:0];
        sq_root[k+1] <= {sq_root[k][RW-2:0], ge};
        sq_x[k+1]    <= sq_x[k] << 2;
        sq_mx[k+1]   <= sq_mx[k];
        sq_my[k+1]   <= sq_my[k];
      end
    end
  end

  // divider pipeline by |dir_z|: lane 0 distance, lanes 1 and 2 lateral offsets
  logic           dv_vld [0:LW];
  logic [SBW-1:0] dv_sb  [0:LW];
  logic [D-1:0]   dv_rem [0:LW][0:2];
  logic [LW-1:0]  dv_num [0:LW][0:2];

  assign dv_vld[0]    = sq_vld[RW];
  assign dv_sb[0]     = sq_sb[RW];
  assign dv_num[0][0] = sq_root[RW];
  assign dv_num[0][1] = sq_mx[RW];
  assign dv_num[0][2] = sq_my[RW];
  for (genvar j = 0; j < 3; j++) begin : g_dv_init
    assign dv_rem[0][j] = '0;
  end

  for (genvar k = 0; k < LW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_sb[k+1] <= dv_sb[k];
      end
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [D:0] cur;
      logic       ge;

      always_comb begin
        cur = {dv_rem[k][j], dv_num[k][j][LW-1]};
        ge  = cur >= {1'b0, dv_sb[k][O_ADZ +: D]};
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem[k+1][j] <= ge ? D'(cur - {1'b0, dv_sb[k][O_ADZ +: D]}) : cur[D-1:0];
          dv_num[k+1][j] <= {dv_num[k][j][LW-2:0], ge};
        end
      end
    end
  end

  // move one coordinate by a signed offset and clip, returns {clipped, value}
  function automatic logic [C:0] move_coord(input logic [C-1:0] p, input logic neg,
                                           input logic [LW-1:0] q);
    logic [LW+1:0] v;
    logic [LW+1:0] v_hi;
    logic [LW+1:0] v_lo;
    v_hi = {{(LW+3-C){1'b0}}, {(C-1){1'b1}}};
    v_lo = {{(LW+3-C){1'b1}}, {(C-1){1'b0}}};
    v    = {{(LW+2-C){p[C-1]}}, p} + (neg ? (~{2'b00, q} + (LW+2)'(1)) : {2'b00, q});
    if ($signed(v) > $signed(v_hi)) begin
      return {1'b1, 1'b0, {(C-1){1'b1}}};
    end else if ($signed(v) < $signed(v_lo)) begin
      return {1'b1, 1'b1, {(C-1){1'b0}}};
    end
    return {1'b0, v[C-1:0]};
  endfunction

  // final assembly of the result item
  logic [SBW-1:0] f_sb;
  logic           f_out, f_zero, f_stay, f_up;
  logic           f_dsat;
  logic [C:0]     f_mx, f_my;
  logic [1:0]     r_face;
  logic           r_outside, r_sat;
  logic [C-1:0]   r_dist, r_hx, r_hy, r_hz;

  always_comb begin
    f_sb   = dv_sb[LW];
    f_out  = f_sb[O_FL + 5];
    f_zero = f_sb[O_FL + 4];
    f_stay = f_sb[O_FL + 3];
    f_up   = f_sb[O_FL + 2];
    f_dsat = dv_num[LW][0][LW-1:C] != '0;
    f_mx   = move_coord(f_sb[O_PX +: C], f_sb[O_FL + 1], dv_num[LW][1]);
    f_my   = move_coord(f_sb[O_PY +: C], f_sb[O_FL], dv_num[LW][2]);
    r_face    = sbh_pkg::FACE_NONE;
    r_outside = 1'b0;
    r_sat     = 1'b0;
    r_dist    = '0;
    r_hx      = '0;
    r_hy      = '0;
    r_hz      = '0;
    if (f_out) begin
      r_outside = 1'b1;
    end else if (!f_zero) begin
      r_face = f_up ? sbh_pkg::FACE_UPPER : sbh_pkg::FACE_LOWER;
      if (f_stay) begin
        r_hx = f_sb[O_PX +: C];
        r_hy = f_sb[O_PY +: C];
        r_hz = f_sb[O_PZ +: C];
      end else begin
        r_dist = f_dsat ? '1 : dv_num[LW][0][C-1:0];
        r_hx   = f_mx[C-1:0];
        r_hy   = f_my[C-1:0];
        r_hz   = f_sb[O_FZ +: C];
        r_sat  = f_dsat || f_mx[C] || f_my[C];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hit.valid <= 1'b0;
    end else if (adv) begin
      hit.valid <= dv_vld[LW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit.face      <= r_face;
      hit.outside   <= r_outside;
      hit.distance  <= r_dist;
      hit.hit_x     <= r_hx;
      hit.hit_y     <= r_hy;
      hit.hit_z     <= r_hz;
      hit.saturated <= r_sat;
    end
  end

  // checks on the result assembly and stall path
  a_outside_clean: assert property (@(posedge clk) disable iff (rst)
    hit.valid && hit.outside |-> hit.face == sbh_pkg::FACE_NONE && hit.distance == '0
      && !hit.saturated)
    else $error("outside item carries non-zero fields");

  a_no_face_clean: assert property (@(posedge clk) disable iff (rst)
    hit.valid && hit.face == sbh_pkg::FACE_NONE |-> hit.distance == '0 && !hit.saturated
      && hit.hit_z == '0)
    else $error("item with no face carries a distance");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    hit.valid && !hit.ready |=> hit.valid && $stable(hit.distance) && $stable(hit.hit_x))
    else $error("stalled result changed");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    hit.valid && !hit.ready |-> !ray.ready)
    else $error("item taken while the pipeline is held");

endmodule

FILE: verif/tb_slab_boundary_hit.sv
// testbench for the slab boundary hit block: exact predictor, directed and random rays
module tb_slab_boundary_hit;

  typedef struct packed {
    logic signed [sbh_pkg::COORD_WIDTH-1:0] pos_x;
    logic signed [sbh_pkg::COORD_WIDTH-1:0] pos_y;
    logic signed [sbh_pkg::COORD_WIDTH-1:0] pos_z;
    logic signed [sbh_pkg::DIR_WIDTH-1:0]   dir_x;
    logic signed [sbh_pkg::DIR_WIDTH-1:0]   dir_y;
    logic signed [sbh_pkg::DIR_WIDTH-1:0]   dir_z;
  } ray_t;

  typedef struct packed {
    sbh_pkg::face_t                  face;
    logic                            outside;
    logic [sbh_pkg::COORD_WIDTH-1:0] distance;
    logic [sbh_pkg::COORD_WIDTH-1:0] hit_x;
    logic [sbh_pkg::COORD_WIDTH-1:0] hit_y;
    logic [sbh_pkg::COORD_WIDTH-1:0] hit_z;
    logic                            saturated;
  } hit_t;

  localparam int PIPE_CYCLES = 6 + 2 * (sbh_pkg::COORD_WIDTH + sbh_pkg::DIR_WIDTH + 1);
  localparam logic signed [63:0] C_MIN = -(64'sd1 <<< (sbh_pkg::COORD_WIDTH - 1));
  localparam logic signed [63:0] C_MAX = (64'sd1 <<< (sbh_pkg::COORD_WIDTH - 1)) - 1;
  // register index with no register behind it
  localparam logic [sbh_pkg::CFG_IDX_WIDTH-1:0] CFG_UNUSED = 2'd3;

  logic clk;
  logic rst;

  sbh_ray_if ray_ch ();
  sbh_hit_if hit_ch ();
  sbh_cfg_if cfg_ch ();

  slab_boundary_hit DUT (
    .clk (clk),
    .rst (rst),
    .ray (ray_ch),
    .hit (hit_ch),
    .cfg (cfg_ch)
  );

  // mirror of the slab registers
  logic signed [sbh_pkg::COORD_WIDTH-1:0] slab_lo;
  logic signed [sbh_pkg::COORD_WIDTH-1:0] slab_hi;
  logic [sbh_pkg::TOL_WIDTH-1:0]          slab_tol;

  hit_t expected_hits[$];
  int   rays_sent;
  int   hits_checked;
  int   mismatches;
  int   outside_seen;
  int   sat_seen;
  bit   idle_on;
  bit   hold_req;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  // offset along one axis, truncated toward zero, then clipped to the coordinate range
  function automatic logic signed [63:0] step_axis(input logic signed [63:0] p,
                                                   input logic signed [63:0] d,
                                                   input logic [63:0] an,
                                                   input logic [63:0] adz,
                                                   inout bit sat);
    logic [127:0]       off;
    logic [127:0]       cap;
    logic [63:0]        ad;
    logic signed [63:0] v;
    cap = 128'd1 << sbh_pkg::COORD_WIDTH;
    ad  = d < 0 ? 64'(-d) : 64'(d);
    off = (128'(ad) * 128'(an)) / 128'(adz);
    if (off > cap) off = cap;
    v = d < 0 ? p - $signed(64'(off)) : p + $signed(64'(off));
    if (v < C_MIN) begin
      sat = 1'b1;
      v = C_MIN;
    end
    if (v > C_MAX) begin
      sat = 1'b1;
      v = C_MAX;
    end
    return v;
  endfunction

  // exact face, distance and hit point for one ray under the current registers
  function automatic hit_t predict_hit(input ray_t r);
    hit_t               h;
    logic signed [63:0] px, py, pz, dx, dy, dz, bot, top, tol, face_z, n, hx, hy;
    logic [63:0]        an, adz, adx, ady;
    logic [191:0]       rhs, d2, cand;
    logic [63:0]        path_len;
    bit                 sat;
    h   = '0;
    sat = 1'b0;
    px  = r.pos_x;
    py  = r.pos_y;
    pz  = r.pos_z;
    dx  = r.dir_x;
    dy  = r.dir_y;
    dz  = r.dir_z;
    bot = slab_lo;
    top = slab_hi;
    tol = $signed({48'd0, slab_tol});
    h.face = sbh_pkg::FACE_NONE;
    if (pz < bot - tol || pz > top + tol) begin
      h.outside = 1'b1;
      return h;
    end
    if (dz == 0) return h;
    face_z = dz > 0 ? top : bot;
    n   = face_z - pz;
    adz = dz < 0 ? 64'(-dz) : 64'(dz);
    if (n == 0 || (n > 0) != (dz > 0)) begin
      // already at or past the face
      path_len = 0;
      hx = px;
      hy = py;
      face_z = pz;
    end else begin
      an  = n < 0 ? 64'(-n) : 64'(n);
      adx = dx < 0 ? 64'(-dx) : 64'(dx);
      ady = dy < 0 ? 64'(-dy) : 64'(dy);
      rhs = 192'(an) * 192'(an) * 192'(adx * adx + ady * ady + adz * adz);
      d2  = 192'(adz * adz);
      if (((192'd1 << (2 * sbh_pkg::COORD_WIDTH)) * d2) <= rhs) begin
        sat  = 1'b1;
        path_len = (64'd1 << sbh_pkg::COORD_WIDTH) - 1;
      end else begin
        path_len = 0;
        for (int b = sbh_pkg::COORD_WIDTH - 1; b >= 0; b--) begin
          cand = 192'(path_len | (64'd1 << b));
          if (cand * cand * d2 <= rhs) path_len = 64'(cand);
        end
      end
      hx = step_axis(px, dx, an, adz, sat);
      hy = step_axis(py, dy, an, adz, sat);
    end
    h.face      = dz > 0 ? sbh_pkg::FACE_UPPER : sbh_pkg::FACE_LOWER;
    h.distance  = path_len[sbh_pkg::COORD_WIDTH-1:0];
    h.hit_x     = hx[sbh_pkg::COORD_WIDTH-1:0];
    h.hit_y     = hy[sbh_pkg::COORD_WIDTH-1:0];
    h.hit_z     = face_z[sbh_pkg::COORD_WIDTH-1:0];
    h.saturated = sat;
    return h;
  endfunction

  // result side: ready with random stalls and an occasional long hold-off
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        hit_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        hit_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        hit_ch.ready <= 1'b0;
      end else begin
        hit_ch.ready <= 1'b1;
      end
    end
  end

  // compare each taken result item with the oldest prediction
  always @(posedge clk) begin
    hit_t got;
    hit_t want;
    if (!rst && hit_ch.valid && hit_ch.ready) begin
      got.face      = sbh_pkg::face_t'(hit_ch.face);
      got.outside   = hit_ch.outside;
      got.distance  = hit_ch.distance;
      got.hit_x     = hit_ch.hit_x;
      got.hit_y     = hit_ch.hit_y;
      got.hit_z     = hit_ch.hit_z;
      got.saturated = hit_ch.saturated;
      hits_checked++;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %p", got);
      end else begin
        want = expected_hits.pop_front();
        if (got.outside) outside_seen++;
        if (got.saturated) sat_seen++;
        if (got.face !== want.face || got.outside !== want.outside ||
            got.distance !== want.distance || got.hit_x !== want.hit_x ||
            got.hit_y !== want.hit_y || got.hit_z !== want.hit_z ||
            got.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at item %0d", hits_checked);
            $display("  exp face=%0d out=%0d dist=%h x=%h y=%h z=%h sat=%0d", want.face,
                     want.outside, want.distance, want.hit_x, want.hit_y, want.hit_z,
                     want.saturated);
            $display("  got face=%0d out=%0d dist=%h x=%h y=%h z=%h sat=%0d", got.face,
                     got.outside, got.distance, got.hit_x, got.hit_y, got.hit_z,
                     got.saturated);
          end
        end
      end
    end
  end

  // offer one ray item, predict on acceptance
  task automatic send_ray(input ray_t r);
    int gap;
    gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      ray_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ray_ch.valid <= 1'b1;
    ray_ch.pos_x <= r.pos_x;
    ray_ch.pos_y <= r.pos_y;
    ray_ch.pos_z <= r.pos_z;
    ray_ch.dir_x <= r.dir_x;
    ray_ch.dir_y <= r.dir_y;
    ray_ch.dir_z <= r.dir_z;
    do @(posedge clk); while (!ray_ch.ready);
    expected_hits.push_back(predict_hit(r));
    rays_sent++;
  endtask

  task automatic send_fields(input logic signed [63:0] px, input logic signed [63:0] py,
                             input logic signed [63:0] pz, input int dx, input int dy,
                             input int dz);
    ray_t r;
    r.pos_x = px[sbh_pkg::COORD_WIDTH-1:0];
    r.pos_y = py[sbh_pkg::COORD_WIDTH-1:0];
    r.pos_z = pz[sbh_pkg::COORD_WIDTH-1:0];
    r.dir_x = dx[sbh_pkg::DIR_WIDTH-1:0];
    r.dir_y = dy[sbh_pkg::DIR_WIDTH-1:0];
    r.dir_z = dz[sbh_pkg::DIR_WIDTH-1:0];
    send_ray(r);
  endtask

  // stop offering and let the pipeline empty
  task automatic drain_block();
    ray_ch.valid <= 1'b0;
    wait (expected_hits.size() == 0);
    repeat (PIPE_CYCLES + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sbh_pkg::CFG_IDX_WIDTH-1:0] idx,
                           input logic [sbh_pkg::COORD_WIDTH-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      sbh_pkg::CFG_BOTTOM: slab_lo = value;
      sbh_pkg::CFG_TOP:    slab_hi = value;
      sbh_pkg::CFG_TOL:    slab_tol = value[sbh_pkg::TOL_WIDTH-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_slab(input logic signed [63:0] bot, input logic signed [63:0] top,
                          input int tol);
    drain_block();
    write_reg(sbh_pkg::CFG_BOTTOM, bot[sbh_pkg::COORD_WIDTH-1:0]);
    write_reg(sbh_pkg::CFG_TOP, top[sbh_pkg::COORD_WIDTH-1:0]);
    write_reg(sbh_pkg::CFG_TOL, tol);
  endtask

  function automatic logic signed [sbh_pkg::DIR_WIDTH-1:0] rand_dir();
    case ($urandom_range(0, 3))
      0:       return sbh_pkg::DIR_WIDTH'($signed($urandom_range(0, 16)) - 8);
      1:       return sbh_pkg::DIR_WIDTH'($signed($urandom_range(0, 512)) - 256);
      default: return sbh_pkg::DIR_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic signed [sbh_pkg::COORD_WIDTH-1:0] rand_coord();
    if ($urandom_range(0, 2) == 0)
      return sbh_pkg::COORD_WIDTH'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    return sbh_pkg::COORD_WIDTH'($urandom);
  endfunction

  // mostly points inside the widened slab, some near a face, some anywhere
  function automatic ray_t rand_ray();
    ray_t               r;
    logic signed [63:0] lo, hi, pz;
    logic [63:0]        span;
    lo = $signed(64'(slab_lo)) - $signed({48'd0, slab_tol});
    hi = $signed(64'(slab_hi)) + $signed({48'd0, slab_tol});
    if (lo < C_MIN) lo = C_MIN;
    if (hi > C_MAX) hi = C_MAX;
    r.pos_x = rand_coord();
    r.pos_y = rand_coord();
    r.dir_x = rand_dir();
    r.dir_y = rand_dir();
    r.dir_z = ($urandom_range(0, 15) == 0) ? '0 : rand_dir();
    case ($urandom_range(0, 9))
      0, 1: pz = $signed(64'(sbh_pkg::COORD_WIDTH'($urandom)));
      2, 3: begin
        pz = ($urandom_range(0, 1) ? $signed(64'(slab_hi)) : $signed(64'(slab_lo)))
             + $signed($urandom_range(0, 64)) - 32;
        if (pz < C_MIN) pz = C_MIN;
        if (pz > C_MAX) pz = C_MAX;
      end
      default: begin
        if (lo <= hi) begin
          span = 64'(hi - lo) + 1;
          pz = lo + $signed({$urandom, $urandom} % span);
        end else begin
          pz = $signed(64'(sbh_pkg::COORD_WIDTH'($urandom)));
        end
      end
    endcase
    r.pos_z = pz[sbh_pkg::COORD_WIDTH-1:0];
    return r;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_ray(rand_ray());
  endtask

  // default slab and hand-picked rays
  task automatic test_directed();
    // default slab 0..1.0: upward, downward, level and zero direction
    send_fields(0, 0, 32'sh8000, 0, 0, 1);
    send_fields(32'sh10000, -32'sh10000, 32'sh8000, 3, -4, -12);
    send_fields(5, 7, 32'sh8000, 100, 100, 0);
    send_fields(5, 7, 32'sh8000, 0, 0, 0);
    // point above and below the slab
    send_fields(1, 2, 32'sh10001, 1, 1, 1);
    send_fields(1, 2, -1, 1, 1, -1);
    // point on each face
    send_fields(9, 9, 32'sh10000, 2, 2, 5);
    send_fields(9, 9, 0, 2, 2, -5);
    // tolerance: just beyond a face counts as inside, distance zero; one step further is outside
    set_slab(0, 32'sh10000, 16'hFFFF);
    send_fields(3, 4, 32'sh1FFFF, 1, 1, 1);
    send_fields(3, 4, -32'shFFFF, -1, 1, -1);
    send_fields(3, 4, 32'sh20000, 1, 1, 1);
    send_fields(3, 4, -32'sh10000, 1, 1, -1);
    // widest slab, extremes of the fields, distance and hit clipping
    set_slab(C_MIN, C_MAX, 16'hFFFF);
    send_fields(0, 0, C_MIN, 32767, -32768, 1);
    send_fields(C_MAX, C_MIN, C_MIN, 32767, 32767, 1);
    send_fields(C_MIN, C_MAX, C_MAX, -32768, -32768, -32768);
    send_fields(C_MIN, C_MAX, C_MAX, -32768, 32767, -1);
    send_fields(-1, -1, 0, 32767, 32767, 32767);
    send_fields(C_MAX, C_MAX, 0, -32768, -32768, 0);
    // bottom above top: inside test follows its formula
    set_slab(32'sh50000, 32'sh10000, 0);
    send_fields(1, 1, 32'sh30000, 1, 1, 1);
    send_fields(1, 1, 32'sh10000, 1, 1, -1);
    send_fields(1, 1, 32'sh50000, 1, 1, 1);
    // unused register index leaves the slab alone
    drain_block();
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    send_fields(1, 1, 32'sh50000, 1, 1, -1);
  endtask

  task automatic test_random_slabs();
    logic signed [63:0] a, b;
    // a few fixed slabs then random ones
    set_slab(0, 32'sh10000, 16'h0100);
    run_random(300);
    set_slab(C_MIN, C_MAX, 16'hFFFF);
    run_random(300);
    set_slab(-32'sh400000, 32'sh400000, 0);
    run_random(300);
    repeat (2) begin
      a = $signed(64'(sbh_pkg::COORD_WIDTH'($urandom)));
      b = $signed(64'(sbh_pkg::COORD_WIDTH'($urandom)));
      if ($urandom_range(0, 3) != 0 && a > b) set_slab(b, a, $urandom_range(0, 65535));
      else set_slab(a, b, $urandom_range(0, 65535));
      run_random(300);
    end
  endtask

  // result side holds off while rays keep coming so the block stalls its input
  task automatic test_backpressure();
    set_slab(-32'sh1000000, 32'sh1000000, 16'h0010);
    hold_req = 1'b1;
    run_random(150);
  endtask

  // back to back, no idling on either side
  task automatic test_full_rate();
    drain_block();
    idle_on = 1'b0;
    run_random(200);
  endtask

  initial begin
    rst = 1'b1;
    idle_on = 1'b1;
    hold_req = 1'b0;
    rays_sent = 0;
    hits_checked = 0;
    mismatches = 0;
    outside_seen = 0;
    sat_seen = 0;
    slab_lo = '0;
    slab_hi = 32'sh10000;
    slab_tol = '0;
    ray_ch.valid = 1'b0;
    ray_ch.pos_x = '0;
    ray_ch.pos_y = '0;
    ray_ch.pos_z = '0;
    ray_ch.dir_x = '0;
    ray_ch.dir_y = '0;
    ray_ch.dir_z = '0;
    hit_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_slabs();
    test_backpressure();
    test_full_rate();

    drain_block();
    $display("sent %0d rays over several slab settings, checked %0d results", rays_sent,
             hits_checked);
    $display("%0d outside, %0d saturated, %0d mismatches", outside_seen, sat_seen,
             mismatches);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
